// ===== rtl/pba_pkg.sv =====
package pba_pkg;

	// datapath sizing
	localparam int CORDIC_STAGES = 16;
	localparam int COORD_WIDTH   = 16;

	// difference of two coordinates, one bit wider
	localparam int DIFF_W = COORD_WIDTH + 1;
	// vector grows by the cordic gain and the diagonal, then gets the guard bits
	localparam int XY_W   = COORD_WIDTH + 3 + CORDIC_STAGES;
	// q16 radians, covers a half turn plus the sum of all rotations
	localparam int Z_W    = 20;
	localparam int RAD_W  = 20;
	localparam int DEG_W  = 18;

	// angle constants, q16 radians and q8 degrees
	localparam int HALF_PI_Q   = 102944;
	localparam int PI_Q        = 2 * HALF_PI_Q;
	localparam int DEG_QUARTER = 23040;

	// arctangent of 2^-i, rounded q16
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_Q16 [ATAN_ENTRIES] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2,
		1, 0, 0, 0, 0, 0, 0, 0
	};

	// degree conversion with the common factor of 32 taken out:
	// deg = floor((rad * 1440 + 3217) / 6434)
	localparam int DEG_NUM  = 2 * DEG_QUARTER / 32;
	localparam int DEG_BIAS = HALF_PI_Q / 32;
	localparam int DEG_DEN  = 2 * HALF_PI_Q / 32;
	// offset in whole quotients that keeps the numerator positive
	localparam int DEG_OFS  = 1 << 17;

	// reciprocal division of the biased numerator
	localparam int NUM_W     = 30;
	localparam int DEN_LOG   = $clog2(DEG_DEN);
	localparam int DEG_SHIFT = NUM_W + DEN_LOG;
	localparam int RECIP_W   = NUM_W + 1;
	localparam int PROD_W    = NUM_W + RECIP_W;
	localparam int QUO_W     = NUM_W - DEN_LOG + 1;
	localparam int REM_W     = NUM_W + 1;
	localparam logic [RECIP_W-1:0] DEG_RECIP = RECIP_W'(
		((64'd1 << DEG_SHIFT) + 64'(DEG_DEN) - 64'd1) / 64'(DEG_DEN));

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [XY_W-1:0]        xy_t;
	typedef logic signed [Z_W-1:0]         z_t;
	typedef logic signed [RAD_W-1:0]       rad_t;
	typedef logic signed [DEG_W-1:0]       deg_t;
	typedef logic        [NUM_W-1:0]       num_t;
	typedef logic        [PROD_W-1:0]      prod_t;
	typedef logic        [QUO_W-1:0]       quo_t;
	typedef logic signed [REM_W-1:0]       rem_t;

endpackage

// ===== rtl/pba_if.sv =====
// point pair request channel
interface pba_req_if;
	logic            valid;
	logic            ready;
	pba_pkg::coord_t from_x;
	pba_pkg::coord_t from_y;
	pba_pkg::coord_t to_x;
	pba_pkg::coord_t to_y;

	modport source (output valid, output from_x, output from_y, output to_x, output to_y,
		input ready);
	modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
		output ready);
endinterface

// angle result channel
interface pba_rsp_if;
	logic            valid;
	logic            ready;
	pba_pkg::deg_t   angle_degrees;
	pba_pkg::rad_t   angle_radians;

	modport source (output valid, output angle_degrees, output angle_radians, input ready);
	modport sink (input valid, input angle_degrees, input angle_radians, output ready);
endinterface

// ===== rtl/point_bearing_angle.sv =====
// bearing of the vector from point A (from_x, from_y) to point B (to_x, to_y)
// req: one request carries both points; it is taken when valid and ready are high
// rsp: one result per request, in request order: angle_radians (q16) and
//      angle_degrees (q8), both measured from +y, in (-270, 90] degrees
// a zero vector gives -90 degrees
// pipeline: one stage forms the difference, one stage per cordic rotation, five stages
//   for the clamp and the degree scaling, then the output register
// throughput: one request per cycle while req.ready is high; every cordic rotation has its own adder stage
// stall: the output register has a spare entry behind it; when rsp.ready is low the
//   pipeline keeps running until the spare entry fills, then the whole pipeline
//   holds and req.ready drops; req.ready comes from registers only
// reset: arst_n clears every valid bit, including those of both output entries; no other state
module point_bearing_angle (
	input  logic          clk,
	input  logic          arst_n,
	pba_req_if.sink       req,
	pba_rsp_if.source     rsp
);

	localparam int N = pba_pkg::CORDIC_STAGES;

	// pipeline advance
	logic en;

	// difference stage
	pba_pkg::diff_t dx, dy, xn, yn;
	logic           neg, zero;
	pba_pkg::z_t    z0;

	// cordic stage registers, entry k feeds rotation k
	logic           cv_sc [N+1];
	logic           cz0_sc [N+1];
	pba_pkg::xy_t   cx_sc [N+1];
	pba_pkg::xy_t   cy_sc [N+1];
	pba_pkg::z_t    cz_sc [N+1];

	// back end stages
	logic           v_s2, v_s3, v_s4, v_s5, v_s6;
	pba_pkg::rad_t  rad_s2, rad_s3, rad_s4, rad_s5, rad_s6;
	pba_pkg::num_t  num_s3, num_s4, num_s5;
	pba_pkg::prod_t prod_s4;
	pba_pkg::quo_t  q0_s5, q0_s6;
	pba_pkg::rem_t  rem_s6;
	pba_pkg::z_t    zc;
	pba_pkg::deg_t  deg;
	int             corr;

	// output register and spare entry
	logic           out_v_q, spare_v_q;
	pba_pkg::deg_t  out_deg_q, spare_deg_q;
	pba_pkg::rad_t  out_rad_q, spare_rad_q;
	logic           push, pop;

	assign en        = !spare_v_q;
	assign req.ready = en;

	// difference vector, folded into the right half plane
	always_comb begin
		dx   = pba_pkg::diff_t'(req.to_x) - pba_pkg::diff_t'(req.from_x);
		dy   = pba_pkg::diff_t'(req.to_y) - pba_pkg::diff_t'(req.from_y);
		neg  = dx[pba_pkg::DIFF_W-1];
		zero = (dx == '0) && (dy == '0);
		xn   = neg ? -dx : dx;
		yn   = neg ? -dy : dy;
		if (!neg) begin
			z0 = '0;
		end else if (!dy[pba_pkg::DIFF_W-1]) begin
			z0 = pba_pkg::z_t'(pba_pkg::PI_Q);
		end else begin
			z0 = pba_pkg::z_t'(-pba_pkg::PI_Q);
		end
	end

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_sc[0] <= 1'b0;
		end else if (en) begin
			cv_sc[0] <= req.valid;
		end
	end

	// first stage payload, vector scaled by the guard bits
	always_ff @(posedge clk) begin
		if (en) begin
			cx_sc[0]  <= pba_pkg::xy_t'(pba_pkg::xy_t'(xn) <<< N);
			cy_sc[0]  <= pba_pkg::xy_t'(pba_pkg::xy_t'(yn) <<< N);
			cz_sc[0]  <= z0;
			cz0_sc[0] <= zero;
		end
	end

	// one vectoring rotation per stage
	for (genvar k = 0; k < N; k++) begin : g_rot
		pba_pkg::xy_t xs, ys;
		pba_pkg::z_t  at;
		logic         up;

		assign xs = cx_sc[k] >>> k;
		assign ys = cy_sc[k] >>> k;
		assign at = (k < pba_pkg::ATAN_ENTRIES) ? pba_pkg::z_t'(pba_pkg::ATAN_Q16[k]) : '0;
		assign up = !cy_sc[k][pba_pkg::XY_W-1] && (cy_sc[k] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_sc[k+1] <= 1'b0;
			end else if (en) begin
				cv_sc[k+1] <= cv_sc[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cz0_sc[k+1] <= cz0_sc[k];
				if (up) begin
					cx_sc[k+1] <= cx_sc[k] + ys;
					cy_sc[k+1] <= cy_sc[k] - xs;
					cz_sc[k+1] <= cz_sc[k] + at;
				end else begin
					cx_sc[k+1] <= cx_sc[k] - ys;
					cy_sc[k+1] <= cy_sc[k] + xs;
					cz_sc[k+1] <= cz_sc[k] - at;
				end
			end
		end
	end

	// clamp to (-pi, pi], zero vector reads as zero angle
	always_comb begin
		if (cz0_sc[N]) begin
			zc = '0;
		end else if (cz_sc[N] > pba_pkg::z_t'(pba_pkg::PI_Q)) begin
			zc = pba_pkg::z_t'(pba_pkg::PI_Q);
		end else if (cz_sc[N] <= pba_pkg::z_t'(-pba_pkg::PI_Q)) begin
			zc = pba_pkg::z_t'(1 - pba_pkg::PI_Q);
		end else begin
			zc = cz_sc[N];
		end
	end

	// rounding correction of the reciprocal quotient
	always_comb begin
		if (rem_s6 < 0) begin
			corr = -1;
		end else if (rem_s6 >= pba_pkg::rem_t'(pba_pkg::DEG_DEN)) begin
			corr = 1;
		end else begin
			corr = 0;
		end
		deg = pba_pkg::deg_t'(int'(q0_s6) + corr - pba_pkg::DEG_OFS);
	end

	// back end valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= cv_sc[N];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// quarter turn, degree numerator, reciprocal product, quotient, remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= pba_pkg::rad_t'(zc - pba_pkg::z_t'(pba_pkg::HALF_PI_Q));

			rad_s3  <= rad_s2;
			num_s3  <= pba_pkg::num_t'(int'(rad_s2) * pba_pkg::DEG_NUM + pba_pkg::DEG_BIAS
				+ pba_pkg::DEG_DEN * pba_pkg::DEG_OFS);

			rad_s4  <= rad_s3;
			num_s4  <= num_s3;
			prod_s4 <= num_s3 * pba_pkg::DEG_RECIP;

			rad_s5  <= rad_s4;
			num_s5  <= num_s4;
			q0_s5   <= prod_s4[pba_pkg::DEG_SHIFT +: pba_pkg::QUO_W];

			rad_s6  <= rad_s5;
			q0_s6   <= q0_s5;
			rem_s6  <= pba_pkg::rem_t'(num_s5) - pba_pkg::rem_t'(q0_s5 * pba_pkg::DEG_DEN);
		end
	end

	// output register with one spare entry
	assign push = en && v_s6;
	assign pop  = out_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else begin
			if (spare_v_q) begin
				if (pop) begin
					spare_v_q <= 1'b0;
				end
			end else if (out_v_q) begin
				if (!pop && push) begin
					spare_v_q <= 1'b1;
				end else if (pop && !push) begin
					out_v_q <= 1'b0;
				end
			end else if (push) begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (pop) begin
				out_deg_q <= spare_deg_q;
				out_rad_q <= spare_rad_q;
			end
		end else if (out_v_q && !pop) begin
			if (push) begin
				spare_deg_q <= deg;
				spare_rad_q <= rad_s6;
			end
		end else if (push) begin
			out_deg_q <= deg;
			out_rad_q <= rad_s6;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.angle_degrees = out_deg_q;
	assign rsp.angle_radians = out_rad_q;

endmodule
